### rtl/smfe_pkg.sv
// ----------------------------------------------------------------------------
// smfe_pkg
// Types, codes and defaults shared by the sorted multiset floor extractor.
// ----------------------------------------------------------------------------
package smfe_pkg;

   localparam int unsigned CAPACITY_DEFAULT   = 1024;
   localparam int unsigned VALUE_BITS_DEFAULT = 32;
   localparam int unsigned COUNT_OUT_BITS     = 11;
   localparam int unsigned VALUE_PORT_BITS    = 32;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                       action;
      logic [VALUE_PORT_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [VALUE_PORT_BITS-1:0] found_value;
      logic [COUNT_OUT_BITS-1:0]  entries_held;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SWAIT,
      S_SHIFT,
      S_DONE
   } state_type;

endpackage

### rtl/sorted_multiset_floor_extract.sv
// ----------------------------------------------------------------------------
// sorted_multiset_floor_extract
// Sorted multiset in one RAM; insert in order, or extract the floor of a value.
// ----------------------------------------------------------------------------
// Usage: drive req_data and pulse start while busy is low; the item is taken
// at that edge and busy rises. Each item yields one result: rsp_valid is high
// for exactly one cycle with rsp_data, and the receiver must take it then.
// Flow: a binary search over the count, each probe a RAM read (one read port,
// registered read data) in S_SEARCH and its compare in S_SWAIT, then a closing
// S_SEARCH, then an element shift through the same RAM, each moved entry read
// and then written, then the S_DONE result state. A search makes at most
// ceil(log2(n+1)) probes for n held values. Busy stays high through S_DONE,
// where the result shows, and the next transfer is taken in the cycle after at
// the earliest. A query that finds nothing skips the shift; a full-store insert
// skips search and shift. Reset clears the count and control state only; the
// RAM needs no clearing since only entries below the count are used.
// ----------------------------------------------------------------------------
module sorted_multiset_floor_extract #(
   parameter int unsigned CAPACITY   = smfe_pkg::CAPACITY_DEFAULT,
   parameter int unsigned VALUE_BITS = smfe_pkg::VALUE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smfe_pkg::req_type req_data,
   output logic              rsp_valid,
   output smfe_pkg::rsp_type rsp_data
);
   import smfe_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [VALUE_BITS-1:0] mem [CAPACITY];
   logic [VALUE_BITS-1:0] rd_data;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  act_ff, act_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]         idx_ff, idx_in;    // shift cursor
   logic [VALUE_BITS-1:0] found_ff, found_in;
   logic [1:0]            stat_ff, stat_in;

   logic [CW-1:0] mid;
   logic [CW:0]   mid_sum;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_SEARCH;
         S_SEARCH: begin
            if (stat_ff != ST_OK) state_in = S_DONE;
            else if (lo_ff < hi_ff) state_in = S_SWAIT;
            else if (act_ff == ACTION_QUERY && lo_ff == '0) state_in = S_DONE;
            else state_in = S_SHIFT;
         end
         S_SWAIT:  state_in = S_SEARCH;
         S_SHIFT:  begin
            if (act_ff == ACTION_INSERT) begin
               if (idx_ff == lo_ff) state_in = S_DONE;
            end else if (idx_ff == count_ff) state_in = S_DONE;
         end
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath; S_SHIFT alternates a read phase (rd pending) and a write phase
   logic ph_ff, ph_in;
   always_comb begin
      count_in = count_ff; act_in = act_ff; val_in = val_ff;
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff; found_in = found_ff;
      stat_in = stat_ff; ph_in = ph_ff;
      rd_addr = mid[AW-1:0];
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      unique case (state_ff)
         S_IDLE: if (start) begin
            act_in = req_data.action;
            val_in = VALUE_BITS'(req_data.value);
            lo_in = '0; hi_in = count_ff; found_in = '0; stat_in = ST_OK; ph_in = 1'b0;
            if (req_data.action == ACTION_INSERT && count_ff >= CW'(CAPACITY))
               stat_in = ST_FULL;
         end
         S_SEARCH: begin
            rd_addr = mid[AW-1:0];
            if (stat_ff == ST_OK && !(lo_ff < hi_ff)) begin
               if (act_ff == ACTION_INSERT) begin
                  idx_in = count_ff;
               end else if (lo_ff == '0) begin
                  stat_in = ST_NOT_FOUND;
               end else begin
                  idx_in = lo_ff;   // next to move down; found read first
                  ph_in = 1'b1;     // first step reads found entry
                  rd_addr = AW'(lo_ff - CW'(1));
               end
            end
         end
         S_SWAIT: begin
            if (rd_data <= val_ff) lo_in = mid + CW'(1);
            else hi_in = mid;
         end
         S_SHIFT: begin
            if (act_ff == ACTION_INSERT) begin
               if (!ph_ff) begin
                  if (idx_ff == lo_ff) begin
                     wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = val_ff;
                     count_in = count_ff + CW'(1);
                  end else begin
                     rd_addr = AW'(idx_ff - CW'(1)); ph_in = 1'b1;
                  end
               end else begin
                  wr_en = 1'b1; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
                  idx_in = idx_ff - CW'(1); ph_in = 1'b0;
               end
            end else begin
               if (ph_ff) begin
                  // rd_data holds entry idx-1 (first time: the found value)
                  if (idx_ff == lo_ff) found_in = rd_data;
                  else begin
                     wr_en = 1'b1; wr_addr = AW'(idx_ff - CW'(2)); wr_data = rd_data;
                  end
                  ph_in = 1'b0;
                  if (idx_ff == count_ff) count_in = count_ff - CW'(1);
               end else begin
                  if (idx_ff != count_ff) begin
                     rd_addr = idx_ff[AW-1:0]; idx_in = idx_ff + CW'(1); ph_in = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ph_ff <= ph_in;
      end
      act_ff <= act_in; val_ff <= val_in; lo_ff <= lo_in; hi_ff <= hi_in;
      idx_ff <= idx_in; found_ff <= found_in; stat_ff <= stat_in;
   end

   // outputs
   always_comb begin
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      rsp_data.status       = stat_ff;
      rsp_data.found_value  = VALUE_PORT_BITS'(found_ff);
      rsp_data.entries_held = COUNT_OUT_BITS'(count_ff);
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count above capacity");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> $stable(count_ff))
      else $error("full insert changed count");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives insert and floor-extract commands into the sorted multiset and checks
// every response against a queue-based predictor of the sorted store.
// ----------------------------------------------------------------------------
module tb;
   import smfe_pkg::*;

   localparam int unsigned CAP = CAPACITY_DEFAULT;
   localparam int unsigned DEEP_FILL = 180;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   sorted_multiset_floor_extract i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // predictor state: ascending values held
   logic [31:0] held_values[$];
   rsp_type     pending_rsp[$];
   int          mismatch_count;
   int          idle_pct;
   int          stall_cycles;
   bit          timed_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_item(req_type item);
      rsp_type r;
      int pos;
      r = '0;
      pos = 0;
      while (pos < held_values.size() && held_values[pos] <= item.value) pos++;
      if (item.action == ACTION_INSERT) begin
         if (held_values.size() >= CAP) r.status = ST_FULL;
         else held_values.insert(pos, item.value);
      end else begin
         if (pos == 0) r.status = ST_NOT_FOUND;
         else begin
            r.status = ST_OK;
            r.found_value = held_values[pos-1];
            held_values.delete(pos-1);
         end
      end
      r.entries_held = COUNT_OUT_BITS'(held_values.size());
      return r;
   endfunction

   // one transfer, with random sender gaps; called and returns at a falling edge
   task automatic send_item(logic act, logic [31:0] val);
      req_type item;
      item.action = act;
      item.value = val;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp = {pending_rsp, predict_item(item)};
      @(negedge clock);
   endtask

   task automatic drain_rsp();
      start <= 1'b0;
      while (pending_rsp.size() != 0 && !timed_out) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (want.status !== rsp_data.status || want.found_value !== rsp_data.found_value
                || want.entries_held !== rsp_data.entries_held) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // watchdog: cycles with no transfer either way
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         timed_out = 1'b1;
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFF0 | $urandom_range(15);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      send_item(ACTION_QUERY, 32'hFFFF_FFFF);   // empty store
      send_item(ACTION_INSERT, 32'd0);
      send_item(ACTION_INSERT, 32'hFFFF_FFFF);
      send_item(ACTION_INSERT, 32'd100);
      send_item(ACTION_INSERT, 32'd100);        // duplicate
      send_item(ACTION_INSERT, 32'hAAAA_5555);
      send_item(ACTION_QUERY, 32'd99);
      send_item(ACTION_QUERY, 32'd100);         // removes one copy
      send_item(ACTION_QUERY, 32'd100);
      send_item(ACTION_QUERY, 32'd0);
      send_item(ACTION_QUERY, 32'd0);           // nothing at or below
      send_item(ACTION_QUERY, 32'h5555_AAAA);
      send_item(ACTION_QUERY, 32'hFFFF_FFFF);
      send_item(ACTION_QUERY, 32'hFFFF_FFFF);
      send_item(ACTION_QUERY, 32'hFFFF_FFFF);
      drain_rsp();
   endtask

   // grow a deep store of many duplicates for long shifts, then empty it
   task automatic test_deep_store();
      int saved;
      saved = idle_pct;
      idle_pct = 0;
      while (held_values.size() < DEEP_FILL) send_item(ACTION_INSERT, $urandom_range(3));
      repeat (6) send_item(ACTION_QUERY, $urandom());
      send_item(ACTION_INSERT, 32'd2);
      while (held_values.size() > 0) send_item(ACTION_QUERY, 32'hFFFF_FFFF);
      drain_rsp();
      idle_pct = saved;
   endtask

   // mostly small stores to keep the shifts short
   task automatic test_random(int count);
      repeat (count) begin
         if (held_values.size() > 40 || (held_values.size() > 0 && $urandom_range(1)))
            send_item(ACTION_QUERY, rand_value());
         else
            send_item(ACTION_INSERT, rand_value());
      end
   endtask

   initial begin
      mismatch_count = 0;
      timed_out = 1'b0;
      idle_pct = 9;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(180);
      drain_rsp();                               // pause until all responses are in
      idle_pct = 88;
      test_random(100);
      idle_pct = 0;
      test_random(180);
      test_deep_store();
      drain_rsp();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

### sorted_multiset_floor_extract.f
rtl/smfe_pkg.sv
rtl/sorted_multiset_floor_extract.sv
verif/tb.sv
